/* sv/esept_pkg.sv */
// Shared types and constants for the edge segment endpoint tracer.
// Used by esept_ctrl, esept_dp and edge_segment_endpoint_tracer_top.
package esept_pkg;

  localparam int unsigned CfgAw = 4;
  localparam logic [1:0] RegRows   = 2'd0;
  localparam logic [1:0] RegCols   = 2'd1;
  localparam logic [1:0] RegLabels = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;     // clear one entry of marks and tables at clr address
    logic clr_rst;      // reset the clear counter
    logic scan_rst;     // reset scan position to (1,1)
    logic scan_adv;     // advance scan position
    logic rd_scan;      // read label and return mark at scan position
    logic start_walk;   // load walk position from scan, mark outward
    logic rd_nb;        // read neighbor at current offset
    logic nb_next;      // move to next neighbor offset
    logic nb_rst;       // reset neighbor offset
    logic take_nb;      // step to neighbor, mark in the active set
    logic mark_ret;     // mark walk position in return set, begin return walk
    logic rd_norm;      // read normal at walk position
    logic wr_first;     // write first-endpoint entry
    logic wr_second;    // write second-endpoint entry
    logic ret_phase;    // active mark set is the return set
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_done;
    logic scan_done;
    logic scan_hit;     // scan pixel is an edge not yet returned
    logic nb_last;      // current offset is the last of the eight
    logic nb_ok;        // neighbor is an edge not yet marked
  } stat_t;

endpackage

/* sv/esept_dp.sv */
// Datapath of the tracer: pixel, mark and table memories plus walk registers.
// Depends on esept_pkg.
module esept_dp import esept_pkg::*; #(
  parameter int unsigned RowW = 8,
  parameter int unsigned ColW = 8,
  parameter int unsigned LabW = 10,
  parameter int unsigned MaxLabels = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output stat_t                stat_o,
  input  logic                 load_i,
  input  logic [10:0]          edge_label_i,
  input  logic signed [15:0]   pixel_normal_i,
  input  logic                 frame_end_i,
  input  logic                 query_i,
  input  logic [10:0]          query_label_i,
  input  logic [8:0]           rows_i,
  input  logic [8:0]           cols_i,
  input  logic [10:0]          labels_i,
  output logic                 res_valid_o,
  output logic [8:0]           first_x_o,
  output logic [8:0]           first_y_o,
  output logic signed [15:0]   first_normal_o,
  output logic [8:0]           second_x_o,
  output logic [8:0]           second_y_o,
  output logic signed [15:0]   second_normal_o
);

  localparam int unsigned AW = RowW + ColW;
  localparam int unsigned Depth = 1 << AW;
  localparam int unsigned LDepth = 1 << LabW;
  localparam int unsigned CW = (AW > LabW) ? AW : LabW;

  logic [10:0]        label_mem [Depth];
  logic [15:0]        normal_mem [Depth];
  logic               out_mem [Depth];
  logic               ret_mem [Depth];
  logic [33:0]        first_mem [LDepth];
  logic [33:0]        second_mem [LDepth];

  // Effective dimensions.
  logic [RowW:0] nr;
  logic [ColW:0] nc;
  logic [11:0]   nl;
  always_comb begin
    nr = (rows_i > 9'((1 << RowW))) ? (RowW+1)'(1 << RowW) : (RowW+1)'(rows_i);
    nc = (cols_i > 9'((1 << ColW))) ? (ColW+1)'(1 << ColW) : (ColW+1)'(cols_i);
    nl = ({1'b0, labels_i} > 12'(MaxLabels)) ? 12'(MaxLabels) : {1'b0, labels_i};
  end

  // Address r + c*nr.
  function automatic logic [AW-1:0] addr_of(input logic [RowW:0] r, input logic [ColW:0] c,
                                            input logic [RowW:0] n);
    logic [AW+1:0] p;
    begin
      p = (AW+2)'(r) + (AW+2)'(c) * (AW+2)'(n);
      return p[AW-1:0];
    end
  endfunction

  logic [AW-1:0] load_pos_q, load_pos_d;
  logic [CW:0]   clr_q;
  logic [RowW:0] sr_q, pr_q, nbr_q;
  logic [ColW:0] sc_q, pc_q, nbc_q;
  logic [3:0]    nb_q;
  logic [10:0]   lab_q;
  logic          keep_q;
  logic [10:0]   rd_lab_q;
  logic          rd_mark_q, rd_in_q;
  logic [15:0]   rd_norm_q;
  logic          busy_rd_q;

  // Neighbor offset: code 0..8 skipping 4 (center); dr = code/3, dc = code%3, each applied minus 1.
  logic [1:0] dr, dc;
  always_comb begin
    case (nb_q)
      4'd0: begin dr = 2'd0; dc = 2'd0; end
      4'd1: begin dr = 2'd0; dc = 2'd1; end
      4'd2: begin dr = 2'd0; dc = 2'd2; end
      4'd3: begin dr = 2'd1; dc = 2'd0; end
      4'd5: begin dr = 2'd1; dc = 2'd2; end
      4'd6: begin dr = 2'd2; dc = 2'd0; end
      4'd7: begin dr = 2'd2; dc = 2'd1; end
      default: begin dr = 2'd2; dc = 2'd2; end
    endcase
  end

  logic [RowW+1:0] cand_r;
  logic [ColW+1:0] cand_c;
  logic            cand_in;
  always_comb begin
    cand_r = (RowW+2)'(pr_q) + (RowW+2)'(dr) - (RowW+2)'(1);
    cand_c = (ColW+2)'(pc_q) + (ColW+2)'(dc) - (ColW+2)'(1);
    cand_in = !cand_r[RowW+1] && !cand_c[ColW+1] &&
              (cand_r < (RowW+2)'(nr)) && (cand_c < (ColW+2)'(nc));
  end

  logic [AW-1:0] rd_addr;
  always_comb begin
    if (cmd_i.rd_scan) rd_addr = addr_of(sr_q, sc_q, nr);
    else if (cmd_i.rd_nb) rd_addr = addr_of(cand_r[RowW:0], cand_c[ColW:0], nr);
    else rd_addr = addr_of(pr_q, pc_q, nr);
  end

  // Pixel and mark memories. The read registers hold until the next read command.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      label_mem[load_pos_q] <= edge_label_i;
      normal_mem[load_pos_q] <= pixel_normal_i;
    end
    if (cmd_i.rd_scan || cmd_i.rd_nb || cmd_i.rd_norm) begin
      rd_lab_q <= label_mem[rd_addr];
      rd_norm_q <= normal_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step && clr_q < (CW+1)'(Depth)) begin
      out_mem[clr_q[AW-1:0]] <= 1'b0;
    end else if (cmd_i.start_walk) begin
      out_mem[addr_of(sr_q, sc_q, nr)] <= 1'b1;
    end else if (cmd_i.take_nb && !cmd_i.ret_phase) begin
      out_mem[addr_of(nbr_q, nbc_q, nr)] <= 1'b1;
    end
    if (cmd_i.clr_step && clr_q < (CW+1)'(Depth)) begin
      ret_mem[clr_q[AW-1:0]] <= 1'b0;
    end else if (cmd_i.mark_ret) begin
      ret_mem[addr_of(pr_q, pc_q, nr)] <= 1'b1;
    end else if (cmd_i.take_nb && cmd_i.ret_phase) begin
      ret_mem[addr_of(nbr_q, nbc_q, nr)] <= 1'b1;
    end
    if (cmd_i.rd_scan || cmd_i.rd_nb) begin
      rd_mark_q <= (cmd_i.rd_scan || cmd_i.ret_phase) ? ret_mem[rd_addr] : out_mem[rd_addr];
    end
  end

  // Endpoint tables.
  logic [LabW-1:0] q_idx;
  logic            q_ok_q;
  logic [33:0]     q_first_q, q_second_q;
  logic [LabW-1:0] wlab;
  assign q_idx = LabW'(query_label_i - 11'd1);
  assign wlab  = LabW'(lab_q - 11'd1);
  logic [33:0] entry;
  assign entry = {9'(pc_q) + 9'd1, 9'(pr_q) + 9'd1, rd_norm_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step && clr_q < (CW+1)'(LDepth)) begin
      first_mem[clr_q[LabW-1:0]] <= '0;
      second_mem[clr_q[LabW-1:0]] <= '0;
    end else begin
      if (cmd_i.wr_first && keep_q) first_mem[wlab] <= entry;
      if (cmd_i.wr_second && keep_q) second_mem[wlab] <= entry;
    end
    q_first_q <= first_mem[q_idx];
    q_second_q <= second_mem[q_idx];
  end

  // Control registers.
  always_comb begin
    load_pos_d = load_pos_q;
    if (load_i) load_pos_d = frame_end_i ? '0 : load_pos_q + AW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_pos_q <= '0;
      clr_q <= '0;
      sr_q <= '0; sc_q <= '0; pr_q <= '0; pc_q <= '0; nbr_q <= '0; nbc_q <= '0;
      nb_q <= '0;
      lab_q <= '0;
      keep_q <= 1'b0;
      rd_in_q <= 1'b0;
      q_ok_q <= 1'b0;
      res_valid_o <= 1'b0;
      busy_rd_q <= 1'b0;
    end else begin
      load_pos_q <= load_pos_d;
      busy_rd_q <= query_i;
      res_valid_o <= busy_rd_q;
      q_ok_q <= query_i && query_label_i != 11'd0 && {1'b0, query_label_i} <= nl;
      if (cmd_i.clr_rst) clr_q <= '0;
      else if (cmd_i.clr_step) clr_q <= clr_q + (CW+1)'(1);
      if (cmd_i.scan_rst) begin
        sr_q <= (RowW+1)'(1); sc_q <= (ColW+1)'(1);
      end else if (cmd_i.scan_adv) begin
        if ((ColW+1)'(sc_q + (ColW+1)'(2)) >= nc) begin
          sc_q <= (ColW+1)'(1); sr_q <= sr_q + (RowW+1)'(1);
        end else sc_q <= sc_q + (ColW+1)'(1);
      end
      if (cmd_i.start_walk) begin
        pr_q <= sr_q; pc_q <= sc_q; lab_q <= rd_lab_q;
        keep_q <= {1'b0, rd_lab_q} <= nl;
      end
      if (cmd_i.rd_nb) begin
        nbr_q <= cand_r[RowW:0]; nbc_q <= cand_c[ColW:0]; rd_in_q <= cand_in;
      end
      if (cmd_i.take_nb) begin
        pr_q <= nbr_q; pc_q <= nbc_q;
      end
      if (cmd_i.nb_rst) nb_q <= '0;
      else if (cmd_i.nb_next) nb_q <= (nb_q == 4'd3) ? 4'd5 : nb_q + 4'd1;
    end
  end

  // Result pipe: the table read and the query flag are registered together, then the output registers take the entry.
  always_ff @(posedge clk_i) begin
    if (busy_rd_q) begin
      {first_x_o, first_y_o, first_normal_o}    <= q_ok_q ? q_first_q : '0;
      {second_x_o, second_y_o, second_normal_o} <= q_ok_q ? q_second_q : '0;
    end
  end

  logic [CW:0] clr_max;
  assign clr_max = (Depth > LDepth) ? (CW+1)'(Depth) : (CW+1)'(LDepth);
  always_comb begin
    stat_o.clr_done  = clr_q >= clr_max - (CW+1)'(1);
    stat_o.scan_done = ({1'b0, sr_q} + (RowW+2)'(2) > (RowW+2)'(nr)) || nc < (ColW+1)'(3);
    stat_o.scan_hit  = rd_lab_q != 11'd0 && !rd_mark_q;
    stat_o.nb_last   = nb_q == 4'd8;
    stat_o.nb_ok     = rd_in_q && rd_lab_q != 11'd0 && !rd_mark_q;
  end

endmodule

/* sv/esept_ctrl.sv */
// Controller state machine of the tracer: clear, scan, outward and return walks.
// Depends on esept_pkg.
module esept_ctrl import esept_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  trace_start_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o,
  output logic  busy_o
);

  localparam logic [3:0] SIdle   = 4'd0;
  localparam logic [3:0] SClear  = 4'd1;
  localparam logic [3:0] SScan   = 4'd2;
  localparam logic [3:0] SScanW  = 4'd3;
  localparam logic [3:0] SScanC  = 4'd4;
  localparam logic [3:0] SNbRd   = 4'd5;
  localparam logic [3:0] SNbW    = 4'd6;
  localparam logic [3:0] SNbC    = 4'd7;
  localparam logic [3:0] SEndRd  = 4'd8;
  localparam logic [3:0] SEndW   = 4'd9;
  localparam logic [3:0] SEndWr  = 4'd10;

  logic [3:0] state_q, state_d;
  logic       ret_q, ret_d;
  // Set by reset: the first clearing pass only zeroes the marks and tables and skips the scan.
  logic       boot_q, boot_d;

  always_comb begin
    state_d = state_q;
    ret_d = ret_q;
    boot_d = boot_q;
    cmd_o = '0;
    cmd_o.ret_phase = ret_q;
    case (state_q)
      SIdle: begin
        cmd_o.clr_rst = 1'b1;
        if (trace_start_i) state_d = SClear;
      end
      SClear: begin
        cmd_o.clr_step = 1'b1;
        cmd_o.scan_rst = 1'b1;
        if (stat_i.clr_done) begin
          boot_d = 1'b0;
          state_d = boot_q ? SIdle : SScan;
        end
      end
      SScan: begin
        if (stat_i.scan_done) state_d = SIdle;
        else begin
          cmd_o.rd_scan = 1'b1;
          state_d = SScanW;
        end
      end
      SScanW: state_d = SScanC;
      SScanC: begin
        if (stat_i.scan_hit) begin
          cmd_o.start_walk = 1'b1;
          cmd_o.nb_rst = 1'b1;
          ret_d = 1'b0;
          state_d = SNbRd;
        end else begin
          cmd_o.scan_adv = 1'b1;
          state_d = SScan;
        end
      end
      SNbRd: begin
        cmd_o.rd_nb = 1'b1;
        state_d = SNbW;
      end
      SNbW: state_d = SNbC;
      SNbC: begin
        if (stat_i.nb_ok) begin
          cmd_o.take_nb = 1'b1;
          cmd_o.nb_rst = 1'b1;
          state_d = SNbRd;
        end else if (!stat_i.nb_last) begin
          cmd_o.nb_next = 1'b1;
          state_d = SNbRd;
        end else begin
          state_d = SEndRd;
        end
      end
      SEndRd: begin
        cmd_o.rd_norm = 1'b1;
        if (!ret_q) cmd_o.mark_ret = 1'b1;
        state_d = SEndW;
      end
      SEndW: state_d = SEndWr;
      SEndWr: begin
        cmd_o.nb_rst = 1'b1;
        if (!ret_q) begin
          cmd_o.wr_first = 1'b1;
          ret_d = 1'b1;
          state_d = SNbRd;
        end else begin
          cmd_o.wr_second = 1'b1;
          cmd_o.scan_adv = 1'b1;
          ret_d = 1'b0;
          state_d = SScan;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear;
      ret_q <= 1'b0;
      boot_q <= 1'b1;
    end else begin
      state_q <= state_d;
      ret_q <= ret_d;
      boot_q <= boot_d;
    end
  end

  assign busy_o = state_q != SIdle || trace_start_i;

endmodule

/* sv/edge_segment_endpoint_tracer_top.sv */
// Top level of the edge segment endpoint tracer: APB registers, controller, datapath.
// Depends on esept_pkg, esept_ctrl and esept_dp.
//
// Usage: a transaction is accepted at a rising edge where start is high and busy
// is low. kind_i = 0 loads one pixel (edge_label_i, pixel_normal_i) at the next
// position in column-major order. A load with frame_end_i set starts the trace:
// busy rises the next cycle and stays high through a clearing pass over the
// visit marks and endpoint tables, then the scan over the interior pixels and
// the walks, which probe neighbors and write endpoints; busy falls in the cycle
// after the controller is idle again. Loads and queries may otherwise follow
// back to back. kind_i = 1 queries the entry for query_label_i; strobe rises
// once the query has passed the query register and the result register, with
// both endpoints, zeros for a label never traced or out of range. While busy is
// low, the throughput of one item per cycle is set by the single pixel memory
// write and the registered table read. The receiver cannot stall, so results
// are simply presented for one cycle. Reset clears the control state and
// restores the register defaults; busy is then high through the same clearing
// pass, so that queries read zeros before the first trace. The pixel stores are
// undefined until loaded. Registers are to be written over APB only while idle;
// the block itself does not enforce it.
module edge_segment_endpoint_tracer_top import esept_pkg::*; #(
  parameter int unsigned RowW = 8,
  parameter int unsigned ColW = 8,
  parameter int unsigned LabW = 10,
  parameter int unsigned MaxLabels = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic                kind_i,
  input  logic [10:0]         edge_label_i,
  input  logic signed [15:0]  pixel_normal_i,
  input  logic                frame_end_i,
  input  logic [10:0]         query_label_i,
  output logic                strobe,
  output logic [8:0]          first_x_o,
  output logic [8:0]          first_y_o,
  output logic signed [15:0]  first_normal_o,
  output logic [8:0]          second_x_o,
  output logic [8:0]          second_y_o,
  output logic signed [15:0]  second_normal_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAw-1:0]    paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [8:0]  rows_q, cols_q;
  logic [10:0] labels_q;
  logic        wr_en;
  logic        acc;
  logic        load, query;
  cmd_t        cmd;
  stat_t       stat;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;

  // Register file.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= 9'd256;
      cols_q <= 9'd256;
      labels_q <= 11'd1024;
    end else if (wr_en) begin
      case (paddr[3:2])
        RegRows:   rows_q <= pwdata[8:0];
        RegCols:   cols_q <= pwdata[8:0];
        RegLabels: labels_q <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegRows:   prdata = {23'd0, rows_q};
      RegCols:   prdata = {23'd0, cols_q};
      RegLabels: prdata = {21'd0, labels_q};
      default:   prdata = '0;
    endcase
  end

  logic ctrl_busy;
  assign acc = start && !busy;
  assign load = acc && !kind_i;
  assign query = acc && kind_i;

  esept_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .trace_start_i(load && frame_end_i),
    .stat_i(stat), .cmd_o(cmd), .busy_o(ctrl_busy)
  );

  // busy is registered from the controller state: high from the cycle after
  // the frame end is accepted, and from reset through the first clearing pass.
  logic busy_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) busy_q <= 1'b1;
    else busy_q <= ctrl_busy;
  end
  assign busy = busy_q;

  esept_dp #(.RowW(RowW), .ColW(ColW), .LabW(LabW), .MaxLabels(MaxLabels)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i(cmd), .stat_o(stat),
    .load_i(load), .edge_label_i, .pixel_normal_i, .frame_end_i,
    .query_i(query), .query_label_i,
    .rows_i(rows_q), .cols_i(cols_q), .labels_i(labels_q),
    .res_valid_o(strobe),
    .first_x_o, .first_y_o, .first_normal_o,
    .second_x_o, .second_y_o, .second_normal_o
  );

  // Each accepted query is followed by its result strobe.
  a_strobe_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    query |=> ##1 strobe) else $error("result strobe missing");
  // No strobe appears without an earlier accepted query.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe |-> $past(query, 2)) else $error("unexpected result strobe");
  // A frame end makes the block busy in the following cycle.
  a_busy_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && frame_end_i) |=> busy) else $error("trace did not start");

endmodule
